/* src/dfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal field parser package
// Status codes, register indexes, character constants and size defaults
// shared by the parser and its channel interfaces.
// ----------------------------------------------------------------------------
package dfp_pkg;

   // Width of a result value and of the range registers
   localparam int VALUE_W = 64;

   // Default accumulator width (parameter range 8 to 64)
   localparam int VALUE_BITS_DEF = 64;

   // Field width limit and its register width
   localparam int         WIDTH_W   = 5;
   localparam logic [4:0] WIDTH_CAP = 5'd20;

   // Characters of interest
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Result status
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NODIGITS  = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_RANGE     = 3'd3,
      ST_MINUSZERO = 3'd4
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FIELD_WIDTH = 2'd0,
      CSR_MIN_VALUE   = 2'd1,
      CSR_MAX_VALUE   = 2'd2
   } csr_index_type;

endpackage

/* src/dfp_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal field parser request channel
// One character per request with valid/ready flow control.
// ----------------------------------------------------------------------------
interface dfp_req_if;

   logic       valid;
   logic       ready;
   logic       present;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output present, output ch, output last, input ready);
   modport sink   (input valid, input present, input ch, input last, output ready);

endinterface

/* src/dfp_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal field parser result channel
// One parsed field per result with valid/ready flow control.
// ----------------------------------------------------------------------------
interface dfp_rsp_if
   import dfp_pkg::*;
();

   logic                      valid;
   logic                      ready;
   status_type                status;
   logic signed [VALUE_W-1:0] value;
   logic [WIDTH_W-1:0]        consumed;

   modport source (output valid, output status, output value, output consumed, input ready);
   modport sink   (input valid, input status, input value, input consumed, output ready);

endinterface

/* src/decimal_integer_field_parser_unit.sv */
`timescale 1ns / 1ps
// Path: a request is held in the input register and, once the result slot is
//   free, a field that ends on it is written to the result register.
// Throughput: one request per cycle while the result slot frees; the field
//   state loop (times ten, minus the digit, overflow check) is combinational.
// Reset: synchronous, active high; clears the pipeline and field state and
//   loads a field width limit of 20 and the full signed 64-bit range.
// ----------------------------------------------------------------------------
// Decimal integer field parser
// Streams ASCII characters, accumulates an optionally signed decimal field
// as a negative number and reports status, value and characters consumed.
// ----------------------------------------------------------------------------
module decimal_integer_field_parser_unit
   import dfp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   dfp_req_if.sink            req_bus,
   dfp_rsp_if.source          rsp_bus,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [VALUE_W-1:0] csr_wr_data
);

   localparam int ACC_W = VALUE_BITS;
   localparam int EXT_W = VALUE_BITS + 4;
   localparam logic signed [ACC_W-1:0] MostNeg = {1'b1, {(ACC_W-1){1'b0}}};

   // Configuration registers
   logic [WIDTH_W-1:0]        width_limit_ff;
   logic signed [VALUE_W-1:0] min_value_ff;
   logic signed [VALUE_W-1:0] max_value_ff;

   // Input register
   logic       s1_valid_ff;
   logic       s1_present_ff;
   logic [7:0] s1_ch_ff;
   logic       s1_last_ff;

   // Field state
   logic                    in_field_ff, in_field_in;
   logic                    neg_ff, neg_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [WIDTH_W-1:0]      wl_ff, wl_in;
   logic [WIDTH_W-1:0]      ct_ff, ct_in;

   // Result register
   logic                      out_valid_ff;
   status_type                out_status_ff, out_status_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [WIDTH_W-1:0]        out_consumed_ff, out_consumed_in;

   // Step working signals
   logic                    step_go;
   logic [WIDTH_W-1:0]      cap_w;
   logic                    starting;
   logic                    cur_neg;
   logic signed [ACC_W-1:0] cur_acc;
   logic [WIDTH_W-1:0]      cur_wl;
   logic [WIDTH_W-1:0]      cur_ct;
   logic                    is_digit;
   logic                    is_minus;
   logic [3:0]              dig;
   logic signed [EXT_W-1:0] acc_wide;
   logic signed [EXT_W-1:0] dig_wide;
   logic signed [EXT_W-1:0] acc_trial;
   logic                    ovf;
   logic [WIDTH_W-1:0]      new_ct;
   logic [WIDTH_W-1:0]      new_wl;

   logic                    do_emit;
   logic                    do_finish;
   status_type              direct_status;
   logic [WIDTH_W-1:0]      direct_consumed;
   logic                    fin_neg;
   logic signed [ACC_W-1:0] fin_acc;
   logic [WIDTH_W-1:0]      fin_ct;
   logic signed [ACC_W-1:0] fin_val;
   logic signed [VALUE_W-1:0] fin_val64;
   status_type              fin_status;

   // Handshakes: the input register moves on whenever the result slot frees
   assign step_go       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || step_go;

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.status   = out_status_ff;
   assign rsp_bus.value    = out_value_ff;
   assign rsp_bus.consumed = out_consumed_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_limit_ff <= WIDTH_CAP;
         min_value_ff   <= {1'b1, {(VALUE_W-1){1'b0}}};
         max_value_ff   <= {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIELD_WIDTH: width_limit_ff <= csr_wr_data[WIDTH_W-1:0];
            CSR_MIN_VALUE:   min_value_ff   <= csr_wr_data;
            CSR_MAX_VALUE:   max_value_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_present_ff <= req_bus.present;
         s1_ch_ff      <= req_bus.ch;
         s1_last_ff    <= req_bus.last;
      end
   end

   // Current field view: a fresh field when idle
   always_comb begin
      cap_w    = (width_limit_ff > WIDTH_CAP) ? WIDTH_CAP : width_limit_ff;
      starting = s1_present_ff && !in_field_ff;
      cur_neg  = in_field_ff ? neg_ff : 1'b0;
      cur_acc  = in_field_ff ? acc_ff : '0;
      cur_wl   = in_field_ff ? wl_ff : cap_w;
      cur_ct   = in_field_ff ? ct_ff : '0;
      is_minus = (s1_ch_ff == CH_MINUS);
      is_digit = (s1_ch_ff >= CH_ZERO) && (s1_ch_ff <= CH_NINE);
      dig      = 4'(s1_ch_ff - CH_ZERO);
   end

   // Digit accumulate: acc*10 - d, checked against the most negative value
   always_comb begin
      acc_wide  = EXT_W'(cur_acc);
      dig_wide  = EXT_W'(dig);
      acc_trial = (acc_wide <<< 3) + (acc_wide <<< 1) - dig_wide;
      ovf       = acc_trial < EXT_W'(MostNeg);
      new_ct    = WIDTH_W'(cur_ct + 5'd1);
      new_wl    = (cur_wl != '0) ? WIDTH_W'(cur_wl - 5'd1) : '0;
   end

   // Step decision
   always_comb begin
      do_emit         = 1'b0;
      do_finish       = 1'b0;
      direct_status   = ST_NODIGITS;
      direct_consumed = '0;
      fin_neg         = cur_neg;
      fin_acc         = cur_acc;
      fin_ct          = cur_ct;
      in_field_in     = in_field_ff;
      neg_in          = neg_ff;
      acc_in          = acc_ff;
      wl_in           = wl_ff;
      ct_in           = ct_ff;

      if (!s1_present_ff) begin
         // end of data: close an open field, else report an empty one
         if (in_field_ff) begin
            do_finish = 1'b1;
         end else begin
            do_emit = 1'b1;
         end
      end else if (starting && cap_w == '0) begin
         do_emit = 1'b1;
      end else if (starting && is_minus) begin
         // leading minus; not taken when the width leaves no room for a digit
         if (cap_w == 5'd1) begin
            do_emit = 1'b1;
         end else begin
            fin_neg = 1'b1;
            fin_acc = '0;
            fin_ct  = 5'd1;
            if (s1_last_ff) begin
               do_finish = 1'b1;
            end else begin
               in_field_in = 1'b1;
               neg_in      = 1'b1;
               acc_in      = '0;
               wl_in       = WIDTH_W'(cap_w - 5'd1);
               ct_in       = 5'd1;
            end
         end
      end else if (!is_digit) begin
         do_finish = 1'b1;
      end else if (ovf) begin
         do_emit         = 1'b1;
         direct_status   = ST_OVERFLOW;
         direct_consumed = cur_ct;
      end else begin
         fin_neg = cur_neg;
         fin_acc = acc_trial[ACC_W-1:0];
         fin_ct  = new_ct;
         if (new_wl == '0 || s1_last_ff) begin
            do_finish = 1'b1;
         end else begin
            in_field_in = 1'b1;
            neg_in      = cur_neg;
            acc_in      = acc_trial[ACC_W-1:0];
            wl_in       = new_wl;
            ct_in       = new_ct;
         end
      end

      // any result returns the parser to idle
      if (do_emit || do_finish) begin
         in_field_in = 1'b0;
         neg_in      = 1'b0;
         acc_in      = '0;
         wl_in       = '0;
         ct_in       = '0;
      end
   end

   // Field close: sign, special cases and range check
   always_comb begin
      fin_val   = fin_neg ? fin_acc : -fin_acc;
      fin_val64 = VALUE_W'(fin_val);
      if (fin_ct == {{(WIDTH_W-1){1'b0}}, fin_neg}) begin
         fin_status = ST_NODIGITS;
      end else if (!fin_neg && fin_acc == MostNeg) begin
         fin_status = ST_OVERFLOW;
      end else if (fin_neg && fin_acc == '0) begin
         fin_status = ST_MINUSZERO;
      end else if (fin_val64 < min_value_ff || fin_val64 > max_value_ff) begin
         fin_status = ST_RANGE;
      end else begin
         fin_status = ST_OK;
      end

      if (do_finish) begin
         out_status_in   = fin_status;
         out_value_in    = (fin_status == ST_OK) ? fin_val64 : '0;
         out_consumed_in = fin_ct;
      end else begin
         out_status_in   = direct_status;
         out_value_in    = '0;
         out_consumed_in = direct_consumed;
      end
   end

   // Field state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_field_ff <= 1'b0;
         neg_ff      <= 1'b0;
         acc_ff      <= '0;
         wl_ff       <= '0;
         ct_ff       <= '0;
      end else if (step_go) begin
         in_field_ff <= in_field_in;
         neg_ff      <= neg_in;
         acc_ff      <= acc_in;
         wl_ff       <= wl_in;
         ct_ff       <= ct_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_go) begin
         out_valid_ff <= do_emit || do_finish;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && (do_emit || do_finish)) begin
         out_status_ff   <= out_status_in;
         out_value_ff    <= out_value_in;
         out_consumed_ff <= out_consumed_in;
      end
   end

   // Checks
   a_fail_zero_value: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != ST_OK |-> out_value_ff == '0)
      else $error("failed field carries a non-zero value");

   a_consumed_cap: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_consumed_ff <= WIDTH_CAP)
      else $error("consumed count beyond the width cap");

   a_open_field_room: assert property (@(posedge clock) disable iff (reset)
      in_field_ff |-> wl_ff != '0 && (6'(wl_ff) + 6'(ct_ff)) <= 6'(WIDTH_CAP))
      else $error("open field has no width left or exceeds the cap");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !in_field_ff |-> acc_ff == '0 && !neg_ff && ct_ff == '0)
      else $error("idle parser holds field state");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal integer field parser testbench
// Streams characters into the parser under random flow control on both
// channels, predicts every parsed field in a cycle-free model of the parser
// and compares status, value and count of consumed characters in order.
// Register settings are changed between phases while the parser is idle.
// ----------------------------------------------------------------------------
module testbench
   import dfp_pkg::*;
();

   localparam int     QUIET_LIMIT = 2000;
   localparam int     DRAIN_SLACK = 4;
   localparam int     HOLD_CYCLES = 150;
   localparam int     IDLE_PCT    = 37;
   localparam longint VAL_MIN     = 64'sh8000_0000_0000_0000;
   localparam longint VAL_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic       present;
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   typedef struct {
      status_type status;
      longint     value;
      logic [4:0] consumed;
   } field_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               csr_wr_en   = 1'b0;
   logic [1:0]         csr_index   = '0;
   logic [VALUE_W-1:0] csr_wr_data = '0;

   dfp_req_if req_bus ();
   dfp_rsp_if rsp_bus ();

   decimal_integer_field_parser_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Request queue, expected fields and bookkeeping
   char_item_type    pending_chars[$];
   field_result_type expected_fields[$];
   int               chars_queued    = 0;
   int               chars_accepted  = 0;
   int               fields_checked  = 0;
   int               mismatch_count  = 0;
   int               settings_run    = 0;
   int               status_seen[5]  = '{default: 0};
   bit               no_idle         = 1'b0;

   // Shadow of the register file
   logic [4:0] cfg_width = WIDTH_CAP;
   longint     cfg_min   = VAL_MIN;
   longint     cfg_max   = VAL_MAX;

   // Field parser state
   bit          parse_in_field = 1'b0;
   bit          parse_negative = 1'b0;
   longint      parse_acc      = 0;
   int unsigned parse_width    = 0;
   int unsigned parse_taken    = 0;

   // ------------------------------------------------------------------------
   // Field prediction
   // ------------------------------------------------------------------------
   function automatic field_result_type close_field(input status_type st,
                                                    input longint val);
      field_result_type r;
      r.status       = st;
      r.value        = val;
      r.consumed     = parse_taken[4:0];
      parse_in_field = 1'b0;
      parse_negative = 1'b0;
      parse_acc      = 0;
      parse_width    = 0;
      parse_taken    = 0;
      return r;
   endfunction

   function automatic field_result_type finish_field();
      int unsigned digits;
      longint      v;
      digits = parse_taken - (parse_negative ? 1 : 0);
      if (digits == 0)
         return close_field(ST_NODIGITS, 0);
      // most negative magnitude needs the minus
      if (!parse_negative && parse_acc == VAL_MIN)
         return close_field(ST_OVERFLOW, 0);
      if (parse_negative && parse_acc == 0)
         return close_field(ST_MINUSZERO, 0);
      v = parse_negative ? parse_acc : -parse_acc;
      if (v < cfg_min || v > cfg_max)
         return close_field(ST_RANGE, 0);
      return close_field(ST_OK, v);
   endfunction

   // Returns 1 when the character closes a field
   function automatic bit predict_char(input logic present, input logic [7:0] ch,
                                       input logic last, output field_result_type res);
      int unsigned w;
      longint      digit;
      res = '{status: ST_OK, value: 0, consumed: '0};
      if (!present) begin
         res = parse_in_field ? finish_field() : close_field(ST_NODIGITS, 0);
         return 1'b1;
      end
      // field start: width limit and optional minus
      if (!parse_in_field) begin
         w = 32'((cfg_width > WIDTH_CAP) ? WIDTH_CAP : cfg_width);
         if (w == 0) begin
            res = close_field(ST_NODIGITS, 0);
            return 1'b1;
         end
         parse_in_field = 1'b1;
         parse_negative = 1'b0;
         parse_acc      = 0;
         parse_taken    = 0;
         parse_width    = w;
         if (ch == CH_MINUS) begin
            if (w == 1) begin
               res = close_field(ST_NODIGITS, 0);
               return 1'b1;
            end
            parse_negative = 1'b1;
            parse_taken    = 1;
            parse_width--;
            if (last) begin
               res = finish_field();
               return 1'b1;
            end
            return 1'b0;
         end
      end
      if (ch < CH_ZERO || ch > CH_NINE) begin
         res = finish_field();
         return 1'b1;
      end
      // accumulate negatively, failing at once on overflow
      digit = longint'(ch - CH_ZERO);
      if (parse_acc < VAL_MIN / 10) begin
         res = close_field(ST_OVERFLOW, 0);
         return 1'b1;
      end
      parse_acc = parse_acc * 10;
      if (parse_acc < VAL_MIN + digit) begin
         res = close_field(ST_OVERFLOW, 0);
         return 1'b1;
      end
      parse_acc = parse_acc - digit;
      parse_taken++;
      if (parse_width > 0)
         parse_width--;
      if (parse_width == 0 || last) begin
         res = finish_field();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("[%0t] field %0d: %s", $time, fields_checked, what);
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : char_driver
      char_item_type    nxt;
      field_result_type res;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.present <= 1'b0;
         req_bus.ch      <= '0;
         req_bus.last    <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            chars_accepted++;
            if (predict_char(req_bus.present, req_bus.ch, req_bus.last, res))
               expected_fields.push_back(res);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_chars.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending_chars.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.present <= nxt.present;
               req_bus.ch      <= nxt.ch;
               req_bus.last    <= nxt.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor, with one long hold-off to back the parser up
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      field_result_type want;
      int               hold_left;
      bit               hold_done;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_fields.size() == 0) begin
               note_mismatch("result with no field pending");
            end else begin
               want = expected_fields.pop_front();
               if (rsp_bus.status !== want.status)
                  note_mismatch($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
               if (rsp_bus.value !== want.value)
                  note_mismatch($sformatf("value %0d, want %0d", rsp_bus.value, want.value));
               if (rsp_bus.consumed !== want.consumed)
                  note_mismatch($sformatf("consumed %0d, want %0d",
                                          rsp_bus.consumed, want.consumed));
               status_seen[int'(want.status)]++;
            end
            fields_checked++;
         end
         if (!hold_done && chars_accepted >= 200 && pending_chars.size() >= 40) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog on cycles with no handshake at all
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_char(input logic present, input logic [7:0] ch, input logic last);
      pending_chars.push_back('{present: present, ch: ch, last: last});
      chars_queued++;
   endtask

   task automatic wait_idle();
      while (chars_accepted != chars_queued || expected_fields.size() != 0)
         @(posedge clock);
      // a request that closes no field may still be in flight
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [VALUE_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_config(input logic [4:0] width, input longint lo, input longint hi);
      wait_idle();
      write_csr(CSR_FIELD_WIDTH, VALUE_W'(width));
      write_csr(CSR_MIN_VALUE, lo);
      write_csr(CSR_MAX_VALUE, hi);
      cfg_width = width;
      cfg_min   = lo;
      cfg_max   = hi;
      settings_run++;
   endtask

   function automatic logic [7:0] any_non_digit();
      int r;
      r = $urandom_range(245);
      if (r >= CH_ZERO)
         r += 10;
      return 8'(r);
   endfunction

   // One well-formed field: optional minus, digits, then a terminator, a last flag or neither
   task automatic add_number_field();
      logic [7:0] digs[$];
      string      base;
      int         kind;
      int         n;
      int         term;
      bit         neg;
      neg  = $urandom_range(1);
      kind = $urandom_range(9);
      term = $urandom_range(3);
      if (kind <= 1) begin
         // around the 64-bit and 32-bit limits
         base = (kind == 0) ? "922337203685477580" : "214748364";
         for (int i = 0; i < base.len(); i++)
            digs.push_back(base[i]);
         digs.push_back(CH_ZERO + 8'($urandom_range(6, 9)));
         if ($urandom_range(3) == 0)
            digs.push_back(CH_ZERO + 8'($urandom_range(9)));
      end else if (kind == 2) begin
         n = $urandom_range(1, 3);
         repeat (n) digs.push_back(CH_ZERO);
      end else begin
         n = (kind == 3) ? $urandom_range(1, 20) : $urandom_range(1, 5);
         repeat (n) digs.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      if (neg)
         push_char(1'b1, CH_MINUS, 1'b0);
      for (int i = 0; i < digs.size(); i++)
         push_char(1'b1, digs[i], term == 0 && i == digs.size() - 1);
      case (term)
         1: push_char(1'b1, any_non_digit(), $urandom_range(1));
         2: push_char(1'b0, 8'($urandom_range(255)), $urandom_range(1));
         default: ;
      endcase
   endtask

   task automatic add_random_chars(input int count);
      int target;
      target = chars_queued + count;
      while (chars_queued < target) begin
         if ($urandom_range(99) < 72)
            add_number_field();
         else
            push_char($urandom_range(99) >= 15, 8'($urandom_range(255)),
                      $urandom_range(3) == 0);
      end
      // close any open field before the next register change
      push_char(1'b0, 8'($urandom_range(255)), $urandom_range(1));
   endtask

   function automatic longint random_bound();
      longint v;
      v = longint'({$urandom, $urandom});
      return v >>> $urandom_range(0, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      longint lo;
      longint hi;
      longint t;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings
      push_char(1'b1, 8'h00, 1'b0);                 // idle non-digit
      push_char(1'b1, 8'hFF, 1'b1);
      push_char(1'b0, 8'hA5, 1'b1);                 // end of data while idle
      push_char(1'b1, CH_MINUS, 1'b0);              // bare minus, ended by a minus
      push_char(1'b1, CH_MINUS, 1'b0);
      push_char(1'b1, CH_ZERO + 8'd7, 1'b0);        // minus in mid-field
      push_char(1'b1, CH_MINUS, 1'b0);
      push_char(1'b1, CH_MINUS, 1'b0);              // minus zero, closed by end of data
      push_char(1'b1, CH_ZERO, 1'b0);
      push_char(1'b1, CH_ZERO, 1'b0);
      push_char(1'b0, 8'h00, 1'b0);
      push_char(1'b1, CH_MINUS, 1'b0);
      push_char(1'b1, CH_ZERO + 8'd4, 1'b0);
      push_char(1'b1, CH_ZERO + 8'd2, 1'b1);
      push_char(1'b1, CH_NINE, 1'b0);
      push_char(1'b1, CH_ZERO + 8'd1, 1'b0);
      push_char(1'b0, 8'hFF, 1'b1);
      // Directed: zero width, then width one
      set_config(5'd0, VAL_MIN, VAL_MAX);
      push_char(1'b1, CH_ZERO + 8'd5, 1'b0);
      push_char(1'b1, CH_MINUS, 1'b1);
      set_config(5'd1, VAL_MIN, VAL_MAX);
      push_char(1'b1, CH_MINUS, 1'b0);              // minus with width one
      push_char(1'b1, CH_ZERO + 8'd3, 1'b0);
      push_char(1'b1, CH_NINE, 1'b1);

      // Random phases over a spread of settings
      set_config(5'd20, VAL_MIN, VAL_MAX);
      no_idle = 1'b1;
      add_random_chars(125);
      wait_idle();
      no_idle = 1'b0;
      set_config(5'd31, -64'sd2147483648, 64'sd2147483647);
      add_random_chars(125);
      lo = random_bound();
      hi = random_bound();
      if (lo > hi) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
      set_config(5'($urandom_range(2, 19)), lo, hi);
      add_random_chars(125);
      set_config(5'd5, -64'sd999, 64'sd999);
      add_random_chars(100);
      set_config(5'd0, 0, 0);
      add_random_chars(30);
      set_config(5'd1, -64'sd5, 64'sd5);
      add_random_chars(60);
      set_config(5'd20, VAL_MAX, VAL_MIN);
      add_random_chars(100);
      set_config(5'($urandom_range(0, 31)), random_bound(), random_bound());
      add_random_chars(100);

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_fields.size() != 0)
         note_mismatch($sformatf("%0d fields never arrived", expected_fields.size()));

      $display("Run covered %0d characters under %0d register settings, %0d fields checked",
               chars_accepted, settings_run, fields_checked);
      $display("  ok %0d, no digits %0d, overflow %0d, out of range %0d, minus zero %0d",
               status_seen[ST_OK], status_seen[ST_NODIGITS], status_seen[ST_OVERFLOW],
               status_seen[ST_RANGE], status_seen[ST_MINUSZERO]);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* decimal_integer_field_parser_unit.f */
src/dfp_pkg.sv
src/dfp_req_if.sv
src/dfp_rsp_if.sv
src/decimal_integer_field_parser_unit.sv
tb/testbench.sv
